@@ rtl/i2cbs_pkg.sv @@
// ----------------------------------------------------------------------------
// i2cbs_pkg
// Shared types and constants of the I2C master bit sequencer.
// ----------------------------------------------------------------------------
package i2cbs_pkg;

  localparam int unsigned NumBusesDef = 4;
  localparam int unsigned BusIdxW     = 4;
  localparam int unsigned ByteW       = 8;
  localparam int unsigned BitCntW     = 4;
  localparam int unsigned PhaseW      = 2;
  localparam int unsigned PollW       = 9;
  localparam int unsigned ApbAddrW    = 3;
  localparam int unsigned ApbDataW    = 32;

  localparam logic [PollW-1:0]   PollLimitRst  = 9'd256;
  localparam logic [BitCntW-1:0] BitsPerByte   = 4'd8;
  localparam logic [BitCntW-1:0] LastBitIdx    = 4'd7;
  // register index, taken from paddr[2]
  localparam logic               RegAckPollLim = 1'b0;

  // command codes; the idle code doubles as the tick mode of an input item
  typedef enum logic [2:0] {
    CmdIdle  = 3'd0,
    CmdStart = 3'd1,
    CmdStop  = 3'd2,
    CmdWait  = 3'd3,
    CmdAck   = 3'd4,
    CmdNack  = 3'd5,
    CmdWrite = 3'd6,
    CmdRead  = 3'd7
  } cmd_e;

  typedef enum logic [1:0] {
    StatOk      = 2'd0,
    StatBusy    = 2'd1,
    StatBadBus  = 2'd2,
    StatUnused  = 2'd3
  } status_e;

  typedef struct packed {
    logic scl;
    logic sda;
  } lines_t;

  typedef struct packed {
    cmd_e               kind;
    logic [PhaseW-1:0]  phase;
    logic [BitCntW-1:0] bit_cnt;
    logic [ByteW-1:0]   shreg;
    logic [PollW-1:0]   poll_cnt;
    logic [BusIdxW-1:0] active_bus;
  } seq_state_t;

  typedef struct packed {
    cmd_e               mode;
    logic [BusIdxW-1:0] bus_index;
    logic [ByteW-1:0]   write_byte;
    logic               sda_sample;
  } item_t;

  typedef struct packed {
    status_e            status;
    logic               ack_seen;
    logic [ByteW-1:0]   read_byte;
    logic               done;
    logic               busy;
    logic [BusIdxW-1:0] driven_bus;
    lines_t             lines;
  } result_t;

endpackage

@@ rtl/i2cbs_step.sv @@
// ----------------------------------------------------------------------------
// i2cbs_step
// Next-state and result logic for one item: command decode and phase steps.
// ----------------------------------------------------------------------------
module i2cbs_step import i2cbs_pkg::*; #(
  parameter int unsigned NUM_BUSES = NumBusesDef
) (
  input  seq_state_t         state_i,
  input  item_t              item_i,
  input  logic [PollW-1:0]   poll_limit_i,
  input  lines_t             lines_rd_i,
  output logic [BusIdxW-1:0] rd_bus_o,
  output seq_state_t         state_o,
  output lines_t             lines_wr_o,
  output result_t            result_o
);

  seq_state_t         nxt;
  lines_t             lv;
  logic               fin;
  logic               accept;
  logic               bad_bus;
  logic [PollW-1:0]   lim;
  logic [PollW-1:0]   poll_inc;
  logic [BitCntW-1:0] bc_inc;
  logic [ByteW-1:0]   sh_shift;

  assign bad_bus  = {1'b0, item_i.bus_index} >= (BusIdxW+1)'(NUM_BUSES);
  assign accept   = (item_i.mode != CmdIdle) && !bad_bus && (state_i.kind == CmdIdle);
  assign rd_bus_o = accept ? item_i.bus_index : state_i.active_bus;
  assign lim      = (poll_limit_i == '0) ? PollW'(1) : poll_limit_i;
  assign poll_inc = state_i.poll_cnt + PollW'(1);
  assign bc_inc   = state_i.bit_cnt + BitCntW'(1);
  assign sh_shift = {state_i.shreg[ByteW-2:0], 1'b0};

  always_comb begin
    nxt = state_i;
    lv  = lines_rd_i;
    fin = 1'b0;
    result_o = '0;
    result_o.status = StatOk;
    if (item_i.mode == CmdIdle) begin
      if (state_i.kind != CmdIdle) begin
        case (state_i.kind) inside
          CmdStart, CmdStop, CmdAck, CmdNack: begin
            if (state_i.phase == PhaseW'(0)) begin
              if (state_i.kind == CmdStart) lv.sda = 1'b0;
              else                          lv.scl = 1'b1;
              nxt.phase = PhaseW'(1);
            end else if (state_i.phase == PhaseW'(1)) begin
              if (state_i.kind == CmdStop) lv.sda = 1'b1;
              else                         lv.scl = 1'b0;
              nxt.phase = PhaseW'(2);
            end else begin
              if (state_i.kind == CmdAck) lv.sda = 1'b1;
              fin = 1'b1;
            end
          end
          CmdWait: begin
            if (state_i.phase == PhaseW'(0)) begin
              nxt.phase = PhaseW'(1);
            end else if (state_i.phase == PhaseW'(1)) begin
              if (!item_i.sda_sample) begin
                nxt.shreg = ByteW'(1);
                lv.scl    = 1'b0;
                nxt.phase = PhaseW'(2);
              end else begin
                nxt.poll_cnt = poll_inc;
                if (poll_inc >= lim) begin
                  lv.scl    = 1'b0;
                  nxt.phase = PhaseW'(2);
                end
              end
            end else begin
              fin = 1'b1;
            end
          end
          CmdWrite: begin
            case (state_i.phase)
              PhaseW'(0): begin
                lv.scl    = 1'b1;
                nxt.phase = PhaseW'(1);
              end
              PhaseW'(1): begin
                lv.scl    = 1'b0;
                nxt.phase = PhaseW'(2);
              end
              PhaseW'(2): begin
                // release sda for the acknowledge after the last bit
                if (state_i.bit_cnt == LastBitIdx) lv.sda = 1'b1;
                nxt.phase = PhaseW'(3);
              end
              default: begin
                nxt.bit_cnt = bc_inc;
                nxt.shreg   = sh_shift;
                if (bc_inc >= BitsPerByte) begin
                  fin = 1'b1;
                end else begin
                  lv.sda    = sh_shift[ByteW-1];
                  nxt.phase = PhaseW'(0);
                end
              end
            endcase
          end
          CmdRead: begin
            if (state_i.phase == PhaseW'(0)) begin
              nxt.shreg = {state_i.shreg[ByteW-2:0], item_i.sda_sample};
              nxt.phase = PhaseW'(1);
            end else if (state_i.phase == PhaseW'(1)) begin
              lv.scl    = 1'b0;
              nxt.phase = PhaseW'(2);
            end else begin
              nxt.bit_cnt = bc_inc;
              if (bc_inc >= BitsPerByte) begin
                fin = 1'b1;
              end else begin
                lv.scl    = 1'b1;
                nxt.phase = PhaseW'(0);
              end
            end
          end
          default: ;
        endcase
        if (fin) begin
          result_o.done = 1'b1;
          if (state_i.kind == CmdRead) result_o.read_byte = nxt.shreg;
          if (state_i.kind == CmdWait) result_o.ack_seen  = nxt.shreg[0];
          nxt.kind  = CmdIdle;
          nxt.phase = '0;
        end
      end
    end else if (bad_bus) begin
      result_o.status = StatBadBus;
    end else if (state_i.kind != CmdIdle) begin
      result_o.status = StatBusy;
    end else begin
      nxt.active_bus = item_i.bus_index;
      nxt.kind       = item_i.mode;
      nxt.phase      = '0;
      nxt.bit_cnt    = '0;
      nxt.shreg      = '0;
      nxt.poll_cnt   = '0;
      case (item_i.mode) inside
        CmdStart, CmdWait: lv = '{scl: 1'b1, sda: 1'b1};
        CmdStop, CmdAck:   lv.sda = 1'b0;
        CmdNack:           lv.sda = 1'b1;
        CmdWrite: begin
          nxt.shreg = item_i.write_byte;
          lv.sda    = item_i.write_byte[ByteW-1];
        end
        default:           lv.scl = 1'b1;
      endcase
    end
    result_o.lines      = lv;
    result_o.driven_bus = nxt.active_bus;
    result_o.busy       = (nxt.kind != CmdIdle);
  end

  assign state_o    = nxt;
  assign lines_wr_o = lv;

endmodule

@@ rtl/i2c_master_bit_sequencer.sv @@
// ----------------------------------------------------------------------------
// i2c_master_bit_sequencer
// Multi-bus I2C master line sequencer driven by command and tick items.
// ----------------------------------------------------------------------------
// Usage: each input item on the s_axis channel is a command (start, stop,
// wait-ack, ack, nack, write byte, read byte) for one bus, or a tick that
// ends one delay period and carries the SDA level sampled in it. Every
// input item yields exactly one result item on m_axis with the SCL/SDA
// levels of the driven bus, busy/done flags, the read byte, the
// acknowledge flag and a status code.
// An item is captured in the input register, its step is computed and
// stored in the output register. One item is taken per cycle unless
// m_axis_tready stalls the output; the limit is the state update of the
// phase sequencer between the two registers.
// When m_axis_tready is low the output register holds its item and the
// input register still takes one more item before s_axis_tready drops.
// Reset releases both lines of every bus, makes the sequencer idle and
// sets ack_poll_limit to 256. The APB port writes ack_poll_limit at
// address 0; it is meant to be written while no command is in progress.
// ----------------------------------------------------------------------------
module i2c_master_bit_sequencer import i2cbs_pkg::*; #(
  parameter int unsigned NUM_BUSES = NumBusesDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // bus_index[3:0], write_byte[11:4], sda_sample[12], zero[15:13]
  input  logic [15:0]         s_axis_tdata,
  // mode[2:0]
  input  logic [2:0]          s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // scl_level[0], sda_level[1], driven_bus[5:2], busy_res[6], done_res[7],
  // read_byte[15:8], ack_seen[16], status[18:17], zero[23:19]
  output logic [23:0]         m_axis_tdata,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready
);

  localparam int unsigned BusW = (NUM_BUSES > 1) ? $clog2(NUM_BUSES) : 1;

  logic               in_valid_q;
  item_t              item_q;
  logic               out_valid_q;
  result_t            res_q;
  logic               adv;
  logic               cfg_wr;
  logic [PollW-1:0]   poll_limit_q;
  seq_state_t         state_q;
  seq_state_t         state_d;
  lines_t             lines_q [NUM_BUSES];
  lines_t             lines_rd;
  lines_t             lines_wr;
  logic [BusIdxW-1:0] rd_bus;
  result_t            res_d;

  assign adv           = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      item_q.mode       <= cmd_e'(s_axis_tuser);
      item_q.bus_index  <= s_axis_tdata[3:0];
      item_q.write_byte <= s_axis_tdata[11:4];
      item_q.sda_sample <= s_axis_tdata[12];
    end
  end

  // configuration
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == RegAckPollLim);
  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegAckPollLim) ? ApbDataW'(poll_limit_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poll_limit_q <= PollLimitRst;
    end else if (cfg_wr) begin
      poll_limit_q <= pwdata[PollW-1:0];
    end
  end

  assign lines_rd = lines_q[rd_bus[BusW-1:0]];

  i2cbs_step #(
    .NUM_BUSES (NUM_BUSES)
  ) u_step (
    .state_i      (state_q),
    .item_i       (item_q),
    .poll_limit_i (poll_limit_q),
    .lines_rd_i   (lines_rd),
    .rd_bus_o     (rd_bus),
    .state_o      (state_d),
    .lines_wr_o   (lines_wr),
    .result_o     (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
      for (int i = 0; i < int'(NUM_BUSES); i++) begin
        lines_q[i] <= '{scl: 1'b1, sda: 1'b1};
      end
    end else if (adv) begin
      state_q                   <= state_d;
      lines_q[rd_bus[BusW-1:0]] <= lines_wr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || m_axis_tready) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'b0, res_q.status, res_q.ack_seen, res_q.read_byte, res_q.done,
                          res_q.busy, res_q.driven_bus, res_q.lines.sda, res_q.lines.scl};

  // a finished command never reports busy in the same item
  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.done |-> !res_q.busy)
    else $error("done reported together with busy");

  // rejected items never finish a command
  a_reject_no_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (res_q.status != StatOk) |-> !res_q.done && !res_q.ack_seen)
    else $error("rejected item reports completion");

  // idle sequencer always rests at phase zero
  a_idle_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.kind == CmdIdle) |-> (state_q.phase == '0))
    else $error("idle with nonzero phase");

  // bit counter never passes a full byte
  a_bit_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.bit_cnt <= BitsPerByte)
    else $error("bit counter out of range");

  // driven bus stays in range
  a_bus_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> ({1'b0, state_q.active_bus} < (BusIdxW+1)'(NUM_BUSES)))
    else $error("active bus out of range");

endmodule

@@ bench/i2c_seq_checker.sv @@
// ----------------------------------------------------------------------------
// i2c_seq_checker
// Watches the item, result and APB channels of the I2C bit sequencer, keeps
// its own copy of the line sequencer state, predicts one result per accepted
// item and compares each result field by field in order.
// ----------------------------------------------------------------------------
module i2c_seq_checker import i2cbs_pkg::*; #(
  parameter int unsigned NUM_BUSES = NumBusesDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  input  logic                s_axis_tready,
  // bus_index[3:0], write_byte[11:4], sda_sample[12], zero[15:13]
  input  logic [15:0]         s_axis_tdata,
  // mode[2:0]
  input  logic [2:0]          s_axis_tuser,
  input  logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // scl_level[0], sda_level[1], driven_bus[5:2], busy_res[6], done_res[7],
  // read_byte[15:8], ack_seen[16], status[18:17], zero[23:19]
  input  logic [23:0]         m_axis_tdata,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  input  logic                pready,
  output int unsigned         fail_count_o,
  output int unsigned         pending_o,
  output logic                seq_busy_o,
  output int unsigned         checked_o
);

  typedef struct packed {
    logic             scl;
    logic             sda;
    logic [3:0]       bus;
    logic             busy;
    logic             done;
    logic [ByteW-1:0] rbyte;
    logic             acked;
    logic [1:0]       status;
  } line_report_t;

  line_report_t expected_lines[$];

  // sequencer copy
  cmd_e               cur_cmd;
  logic [2:0]         phase;
  logic [BitCntW-1:0] bits_done;
  logic [ByteW-1:0]   shifter;
  logic [PollW-1:0]   polls;
  logic [BusIdxW-1:0] bus_sel;
  lines_t             lvl [NUM_BUSES];
  logic [PollW-1:0]   poll_lim;

  int unsigned errors = 0;
  int unsigned checked = 0;

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
    seq_busy_o   = 1'b0;
    checked_o    = 0;
  end

  function automatic void set_scl(logic v);
    lvl[bus_sel].scl = v;
  endfunction

  function automatic void set_sda(logic v);
    lvl[bus_sel].sda = v;
  endfunction

  // one delay period ends; returns 1 when the command finishes
  function automatic bit advance_phase(logic sda);
    logic [PollW-1:0] lim;
    lim = (poll_lim == '0) ? PollW'(1) : poll_lim;
    case (cur_cmd)
      CmdStart: begin
        if (phase == 0) begin set_sda(1'b0); phase = 1; return 1'b0; end
        if (phase == 1) begin set_scl(1'b0); phase = 2; return 1'b0; end
        return 1'b1;
      end
      CmdStop: begin
        if (phase == 0) begin set_scl(1'b1); phase = 1; return 1'b0; end
        if (phase == 1) begin set_sda(1'b1); phase = 2; return 1'b0; end
        return 1'b1;
      end
      CmdAck: begin
        if (phase == 0) begin set_scl(1'b1); phase = 1; return 1'b0; end
        if (phase == 1) begin set_scl(1'b0); phase = 2; return 1'b0; end
        set_sda(1'b1);
        return 1'b1;
      end
      CmdNack: begin
        if (phase == 0) begin set_scl(1'b1); phase = 1; return 1'b0; end
        if (phase == 1) begin set_scl(1'b0); phase = 2; return 1'b0; end
        return 1'b1;
      end
      CmdWait: begin
        if (phase == 0) begin phase = 1; return 1'b0; end
        if (phase == 1) begin
          if (sda == 1'b0) begin
            // bit 0 of the shifter holds the ack flag
            shifter = 8'd1;
            set_scl(1'b0);
            phase = 2;
          end else begin
            polls = polls + 1'b1;
            if (polls >= lim) begin set_scl(1'b0); phase = 2; end
          end
          return 1'b0;
        end
        return 1'b1;
      end
      CmdWrite: begin
        if (phase == 0) begin set_scl(1'b1); phase = 1; return 1'b0; end
        if (phase == 1) begin set_scl(1'b0); phase = 2; return 1'b0; end
        if (phase == 2) begin
          // release sda once the last bit has been clocked
          if (bits_done == LastBitIdx) set_sda(1'b1);
          phase = 3;
          return 1'b0;
        end
        bits_done = bits_done + 1'b1;
        shifter = {shifter[ByteW-2:0], 1'b0};
        if (bits_done >= BitsPerByte) return 1'b1;
        set_sda(shifter[ByteW-1]);
        phase = 0;
        return 1'b0;
      end
      CmdRead: begin
        if (phase == 0) begin
          shifter = {shifter[ByteW-2:0], sda};
          phase = 1;
          return 1'b0;
        end
        if (phase == 1) begin set_scl(1'b0); phase = 2; return 1'b0; end
        bits_done = bits_done + 1'b1;
        if (bits_done >= BitsPerByte) return 1'b1;
        set_scl(1'b1);
        phase = 0;
        return 1'b0;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic line_report_t predict_lines(cmd_e mode, logic [BusIdxW-1:0] bus,
                                                 logic [ByteW-1:0] wbyte, logic sda);
    line_report_t r;
    cmd_e         was;
    r = '0;
    r.status = StatOk;
    if (mode == CmdIdle) begin
      if (cur_cmd != CmdIdle) begin
        was = cur_cmd;
        if (advance_phase(sda)) begin
          r.done = 1'b1;
          if (was == CmdRead) r.rbyte = shifter;
          if (was == CmdWait) r.acked = shifter[0];
          cur_cmd = CmdIdle;
          phase = 0;
        end
      end
    end else if (bus >= NUM_BUSES) begin
      r.status = StatBadBus;
    end else if (cur_cmd != CmdIdle) begin
      r.status = StatBusy;
    end else begin
      bus_sel   = bus;
      cur_cmd   = mode;
      phase     = 0;
      bits_done = '0;
      shifter   = '0;
      polls     = '0;
      case (mode)
        CmdStart: begin set_sda(1'b1); set_scl(1'b1); end
        CmdStop:  set_sda(1'b0);
        CmdWait:  begin set_sda(1'b1); set_scl(1'b1); end
        CmdAck:   set_sda(1'b0);
        CmdNack:  set_sda(1'b1);
        CmdWrite: begin shifter = wbyte; set_sda(wbyte[ByteW-1]); end
        default:  set_scl(1'b1);
      endcase
    end
    r.scl  = lvl[bus_sel].scl;
    r.sda  = lvl[bus_sel].sda;
    r.bus  = bus_sel;
    r.busy = (cur_cmd != CmdIdle);
    return r;
  endfunction

  function automatic line_report_t unpack_result(logic [23:0] d);
    line_report_t r;
    r.scl    = d[0];
    r.sda    = d[1];
    r.bus    = d[5:2];
    r.busy   = d[6];
    r.done   = d[7];
    r.rbyte  = d[15:8];
    r.acked  = d[16];
    r.status = d[18:17];
    return r;
  endfunction

  task automatic note_mismatch(string field, logic [7:0] got, logic [7:0] want);
    $display("mismatch at result %0d: %s got %0h expected %0h", checked, field, got, want);
    errors++;
  endtask

  always @(posedge clk_i) begin
    line_report_t got;
    line_report_t want;
    if (!rst_ni) begin
      cur_cmd   = CmdIdle;
      phase     = 0;
      bits_done = '0;
      shifter   = '0;
      polls     = '0;
      bus_sel   = '0;
      poll_lim  = PollLimitRst;
      for (int i = 0; i < NUM_BUSES; i++) lvl[i] = '{scl: 1'b1, sda: 1'b1};
      expected_lines.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr[2] == RegAckPollLim)
        poll_lim = pwdata[PollW-1:0];
      if (s_axis_tvalid && s_axis_tready)
        expected_lines.push_back(predict_lines(cmd_e'(s_axis_tuser), s_axis_tdata[3:0],
                                               s_axis_tdata[11:4], s_axis_tdata[12]));
      if (m_axis_tvalid && m_axis_tready) begin
        got = unpack_result(m_axis_tdata);
        if (expected_lines.size() == 0) begin
          note_mismatch("unexpected result", got.status, '0);
        end else begin
          want = expected_lines.pop_front();
          if (got.scl !== want.scl) note_mismatch("scl_level", got.scl, want.scl);
          if (got.sda !== want.sda) note_mismatch("sda_level", got.sda, want.sda);
          if (got.bus !== want.bus) note_mismatch("driven_bus", got.bus, want.bus);
          if (got.busy !== want.busy) note_mismatch("busy_res", got.busy, want.busy);
          if (got.done !== want.done) note_mismatch("done_res", got.done, want.done);
          if (got.rbyte !== want.rbyte) note_mismatch("read_byte", got.rbyte, want.rbyte);
          if (got.acked !== want.acked) note_mismatch("ack_seen", got.acked, want.acked);
          if (got.status !== want.status) note_mismatch("status", got.status, want.status);
        end
        checked++;
      end
    end
    fail_count_o <= errors;
    pending_o    <= expected_lines.size();
    seq_busy_o   <= (cur_cmd != CmdIdle);
    checked_o    <= checked;
  end

endmodule

@@ bench/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Stimulus for the I2C master bit sequencer: directed commands, poll limit
// changes between idle phases and random command runs with noise, under
// random stalls on both channels; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb import i2cbs_pkg::*;;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                s_valid = 1'b0;
  logic                s_ready;
  logic [15:0]         s_data = '0;
  logic [2:0]          s_user = '0;
  logic                m_valid;
  logic                m_ready = 1'b1;
  logic [23:0]         m_data;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ApbAddrW-1:0] paddr = '0;
  logic [ApbDataW-1:0] pwdata = '0;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  int unsigned fail_count;
  int unsigned pending;
  logic        seq_busy;
  int unsigned checked;

  bit          gaps_on = 1'b0;
  int unsigned items_sent = 0;
  logic [8:0]  poll_limit = PollLimitRst;

  i2c_master_bit_sequencer #(.NUM_BUSES(NumBusesDef)) dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_ready),
    .s_axis_tdata  (s_data),
    .s_axis_tuser  (s_user),
    .m_axis_tvalid (m_valid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_data),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  i2c_seq_checker #(.NUM_BUSES(NumBusesDef)) u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_ready),
    .s_axis_tdata  (s_data),
    .s_axis_tuser  (s_user),
    .m_axis_tvalid (m_valid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_data),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .pready        (pready),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .seq_busy_o    (seq_busy),
    .checked_o     (checked)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
  end

  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // result side stalls
  initial begin
    forever begin
      @(posedge clk);
      if (gaps_on && $urandom_range(0, 4) == 0) begin
        m_ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
        m_ready <= 1'b1;
      end
    end
  end

  task automatic send_item(cmd_e mode, logic [3:0] bus, logic [7:0] wbyte, logic sda);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      s_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    s_valid <= 1'b1;
    s_user  <= mode;
    s_data  <= {3'b000, sda, wbyte, bus};
    @(posedge clk);
    while (!s_ready) @(posedge clk);
    items_sent++;
  endtask

  // low_odds: 0 never low, 1 always low, n low one time in n
  function automatic logic pick_sda(int unsigned low_odds);
    if (low_odds == 0) return 1'b1;
    return ($urandom_range(1, low_odds) == 1) ? 1'b0 : 1'b1;
  endfunction

  task automatic tick(logic sda);
    send_item(CmdIdle, 4'($urandom), 8'($urandom), sda);
  endtask

  // now and then a command that is always refused, since one is in progress
  task automatic maybe_reject();
    if ($urandom_range(0, 11) == 0)
      send_item(cmd_e'($urandom_range(1, 7)), 4'($urandom), 8'($urandom), 1'($urandom));
  endtask

  // one command followed by exactly the ticks that finish it
  task automatic run_command(cmd_e mode, logic [3:0] bus, logic [7:0] wbyte,
                             int unsigned low_odds);
    int unsigned lim;
    int unsigned polls;
    int unsigned ticks;
    logic        s;
    bit          acked;
    lim = (poll_limit == 0) ? 1 : poll_limit;
    send_item(mode, bus, wbyte, 1'($urandom));
    if (mode == CmdWait) begin
      maybe_reject();
      tick(1'($urandom));
      polls = 0;
      acked = 1'b0;
      while (!acked && polls < lim) begin
        s = pick_sda(low_odds);
        maybe_reject();
        tick(s);
        if (s == 1'b0) acked = 1'b1;
        else polls++;
      end
      maybe_reject();
      tick(1'($urandom));
    end else begin
      case (mode)
        CmdWrite: ticks = 32;
        CmdRead:  ticks = 24;
        default:  ticks = 3;
      endcase
      repeat (ticks) begin
        maybe_reject();
        tick(pick_sda(low_odds));
      end
    end
  endtask

  // hold the sender until every result is in and no command is left open
  task automatic settle();
    s_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    while (seq_busy) begin
      tick(1'b0);
      s_valid <= 1'b0;
      do @(posedge clk); while (pending != 0);
    end
  endtask

  task automatic write_poll_limit(logic [8:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {RegAckPollLim, 2'b00};
    pwdata  <= ApbDataW'(v);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    poll_limit = v;
  endtask

  initial begin
    logic [8:0]  limits [6];
    int unsigned start_cnt;
    cmd_e        mode;
    wait (rst_n === 1'b1);
    @(posedge clk);

    // directed: idle ticks, bad bus, busy refusal, every command, byte extremes
    tick(1'b0);
    tick(1'b1);
    send_item(CmdStart, 4'd4, 8'h00, 1'b0);
    send_item(CmdRead, 4'd15, 8'hFF, 1'b1);
    send_item(CmdStart, 4'd0, 8'h00, 1'b0);
    tick(1'b1);
    send_item(CmdWrite, 4'd1, 8'h5A, 1'b0);
    send_item(CmdStop, 4'd15, 8'h00, 1'b1);
    tick(1'b0);
    tick(1'b1);
    run_command(CmdWrite, 4'd1, 8'hFF, 2);
    run_command(CmdWrite, 4'd3, 8'h00, 2);
    run_command(CmdWrite, 4'd2, 8'hA5, 2);
    run_command(CmdRead, 4'd2, 8'h00, 2);
    run_command(CmdRead, 4'd3, 8'h00, 1);
    run_command(CmdRead, 4'd1, 8'h00, 0);
    run_command(CmdWait, 4'd0, 8'h00, 1);
    run_command(CmdWait, 4'd3, 8'h00, 3);
    run_command(CmdAck, 4'd1, 8'h00, 2);
    run_command(CmdNack, 4'd2, 8'h00, 2);
    run_command(CmdStop, 4'd0, 8'h00, 2);
    run_command(CmdStart, 4'd3, 8'h00, 2);

    // zero acts as one, above 256 is used as given
    limits = '{9'd1, 9'd0, 9'd511, 9'd2, 9'd3, 9'($urandom_range(1, 40))};
    foreach (limits[k]) begin
      gaps_on = 1'b0;
      settle();
      write_poll_limit(limits[k]);
      // poll until the limit runs out with no acknowledge
      run_command(CmdWait, 4'($urandom_range(0, NumBusesDef - 1)), 8'($urandom), 0);
      start_cnt = items_sent;
      while (items_sent - start_cnt < 30) begin
        gaps_on = (k != 5) && ($urandom_range(0, 3) != 0);
        if ($urandom_range(0, 4) == 0) begin
          // noise, possibly leaving a command half done
          repeat ($urandom_range(1, 4))
            send_item(cmd_e'($urandom_range(0, 7)), 4'($urandom), 8'($urandom),
                      1'($urandom));
          settle();
        end else begin
          mode = cmd_e'($urandom_range(1, 7));
          run_command(mode, 4'($urandom_range(0, NumBusesDef - 1)), 8'($urandom),
                      $urandom_range(2, 8));
          if ($urandom_range(0, 5) == 0) repeat ($urandom_range(1, 2)) tick(1'($urandom));
        end
      end
    end

    gaps_on = 1'b0;
    settle();
    repeat (8) @(posedge clk);
    $display("covered %0d items and %0d results over all commands, refusals and bad buses",
             items_sent, checked);
    $display("poll limits 256, 1, 0, 511, 2, 3 and %0d, with and without stalls",
             limits[5]);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ i2c_master_bit_sequencer.f @@
rtl/i2cbs_pkg.sv
rtl/i2cbs_step.sv
rtl/i2c_master_bit_sequencer.sv
bench/i2c_seq_checker.sv
bench/tb.sv
